// File: rtl/dlq_pkg.sv
// ----------------------------------------------------------------------------
// dlq_pkg
// Shared sizes, codes and types of the delta-list timer queue.
// ----------------------------------------------------------------------------
package dlq_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int LINK_W      = $clog2(TIMER_SLOTS + 1);
  localparam int LINK_DEPTH  = TIMER_SLOTS + 1;

  // head sentinel sits past the last slot
  localparam logic [LINK_W-1:0] HEAD_IDX = LINK_W'(TIMER_SLOTS);

  // result status codes
  localparam logic [2:0] ST_QUEUED    = 3'd0;
  localparam logic [2:0] ST_INSTANT   = 3'd1;
  localparam logic [2:0] ST_INFINITE  = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_INACTIVE  = 3'd4;

  // request kinds
  localparam logic CMD_SET    = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;

  // write port of a link store
  typedef struct packed {
    logic              we;
    logic [LINK_W-1:0] addr;
    logic [LINK_W-1:0] data;
  } link_wr_t;

endpackage

// File: rtl/dlq_link_ram.sv
// ----------------------------------------------------------------------------
// dlq_link_ram
// Link store: one write and one registered read per cycle. Entries never
// written since reset read as the head sentinel.
// ----------------------------------------------------------------------------
module dlq_link_ram
  import dlq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  link_wr_t          wr,
  input  logic [LINK_W-1:0] raddr,
  output logic [LINK_W-1:0] rdata
);

  logic [LINK_W-1:0]     mem [LINK_DEPTH];
  logic [LINK_DEPTH-1:0] valid_r;
  logic [LINK_W-1:0]     rdata_r;
  logic                  rsel_ok;

  assign rsel_ok = (raddr <= HEAD_IDX);

  // storage and read register
  always_ff @(posedge clk) begin
    if (wr.we && wr.addr <= HEAD_IDX) begin
      mem[wr.addr] <= wr.data;
    end
    if (rsel_ok && valid_r[raddr]) begin
      rdata_r <= mem[raddr];
    end else begin
      rdata_r <= HEAD_IDX;
    end
  end

  // per-entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.we && wr.addr <= HEAD_IDX) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/delta_list_timer_queue.sv
// Steps: read the slot's links and delta; unlink a queued slot; a cancel of a queued
//   slot then reads the new head's delta for the expiry update; a positive set scales
//   delay and tolerance, walks past shorter deltas and links the slot in (INS1, INS2).
// Throughput: one word at a time; the next word is taken the cycle after the result
//   is registered, which waits while an earlier result is still held.
// Reset: synchronous, active low; queue empty, ticks_per_unit = 1.
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Delta-ordered timer queue with memory-held links and deltas.
// ----------------------------------------------------------------------------
module delta_list_timer_queue
  import dlq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // config: ticks_per_unit
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data,
  // in_tdata: slot[3:0], delay_units[35:4], tolerance_units[66:36],
  //           time_now[130:67], time_last_tick[194:131], zero pad
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [199:0] in_tdata,
  // in_tuser: command
  input  logic         in_tuser,
  // out_tdata: expiry_time[63:0], slot_echo[67:64], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,
  // out_tuser: status[2:0], expiry_update[3]
  output logic [3:0]   out_tuser
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDS   = 4'd1;
  localparam logic [3:0] S_UNL1  = 4'd2;
  localparam logic [3:0] S_UNL2  = 4'd3;
  localparam logic [3:0] S_BR    = 4'd4;
  localparam logic [3:0] S_CRD   = 4'd5;
  localparam logic [3:0] S_CF    = 4'd6;
  localparam logic [3:0] S_CEXP  = 4'd7;
  localparam logic [3:0] S_MUL1  = 4'd8;
  localparam logic [3:0] S_MUL2  = 4'd9;
  localparam logic [3:0] S_WST   = 4'd10;
  localparam logic [3:0] S_WALK  = 4'd11;
  localparam logic [3:0] S_INS1  = 4'd12;
  localparam logic [3:0] S_INS2  = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;

  logic [3:0] state_r, state_nxt;

  // request registers
  logic              cmd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [31:0]       delay_r;
  logic [30:0]       tol_u_r;
  logic [63:0]       now_r, last_r;
  logic              was_act_r;
  logic [31:0]       tpu_r;

  // working registers
  logic [LINK_W-1:0] nx_r, pv_r, succ_r, first_r;
  logic [LINK_W-1:0] guard_r;
  logic [63:0]       ds_r, dj_r, delayj_r, tol_r, dsucc_r;
  logic [2:0]        res_status_r;
  logic              res_upd_r;
  logic [63:0]       res_exp_r;

  // output register
  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic              out_upd_r;
  logic [63:0]       out_exp_r;
  logic [SLOT_W-1:0] out_slot_r;

  logic [TIMER_SLOTS-1:0] act_r;

  // delta memory
  logic [63:0]       dmem [TIMER_SLOTS];
  logic [63:0]       drd_r;
  logic [SLOT_W-1:0] draddr;
  logic              dwe;
  logic [SLOT_W-1:0] dwaddr;
  logic [63:0]       dwdata;

  // link stores
  link_wr_t          nwr, pwr;
  logic [LINK_W-1:0] lraddr;
  logic [LINK_W-1:0] nrd, prd;

  // shared multiplier
  logic [31:0] mul_a;
  logic [63:0] mul_p;

  logic        in_acc;
  logic        walk_go;
  logic [63:0] ds2;
  logic        succ_real;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign mul_a = (state_r == S_MUL1) ? delay_r : {1'b0, tol_u_r};
  assign mul_p = 64'(mul_a) * 64'(tpu_r);

  assign succ_real = (succ_r != HEAD_IDX);
  assign walk_go   = succ_real && (guard_r < LINK_W'(TIMER_SLOTS)) && (drd_r < dj_r);
  assign ds2       = dsucc_r - dj_r;

  dlq_link_ram u_next (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (nwr),
    .raddr (lraddr),
    .rdata (nrd)
  );

  dlq_link_ram u_prev (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (pwr),
    .raddr (lraddr),
    .rdata (prd)
  );

  // memory addresses and writes per state
  always_comb begin
    lraddr = HEAD_IDX;
    draddr = slot_r;
    dwe    = 1'b0;
    dwaddr = slot_r;
    dwdata = dj_r;
    nwr    = '0;
    pwr    = '0;
    unique case (state_r)
      S_RDS: begin
        lraddr = {1'b0, slot_r};
      end
      S_UNL1: begin
        draddr = nrd[SLOT_W-1:0];
        if (was_act_r) begin
          nwr = '{we: 1'b1, addr: prd, data: nrd};
          pwr = '{we: 1'b1, addr: nrd, data: prd};
        end
      end
      S_UNL2: begin
        dwe    = (nx_r != HEAD_IDX);
        dwaddr = nx_r[SLOT_W-1:0];
        dwdata = drd_r + ds_r;
      end
      S_CF: begin
        draddr = nrd[SLOT_W-1:0];
      end
      S_MUL2: begin
        lraddr = HEAD_IDX;
      end
      S_WST: begin
        lraddr = nrd;
        draddr = nrd[SLOT_W-1:0];
      end
      S_WALK: begin
        lraddr = nrd;
        draddr = nrd[SLOT_W-1:0];
      end
      S_INS1: begin
        dwe    = 1'b1;
        dwaddr = slot_r;
        dwdata = (succ_real && ds2 < tol_r) ? dsucc_r : dj_r;
        nwr    = '{we: 1'b1, addr: {1'b0, slot_r}, data: succ_r};
        pwr    = '{we: 1'b1, addr: {1'b0, slot_r}, data: pv_r};
      end
      S_INS2: begin
        dwe    = succ_real;
        dwaddr = succ_r[SLOT_W-1:0];
        dwdata = (ds2 < tol_r) ? 64'd0 : ds2;
        nwr    = '{we: 1'b1, addr: pv_r, data: {1'b0, slot_r}};
        pwr    = '{we: 1'b1, addr: succ_r, data: {1'b0, slot_r}};
      end
      default: begin
      end
    endcase
  end

  // delta memory
  always_ff @(posedge clk) begin
    if (dwe) begin
      dmem[dwaddr] <= dwdata;
    end
    drd_r <= dmem[draddr];
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_RDS;
      S_RDS:  state_nxt = S_UNL1;
      S_UNL1: state_nxt = was_act_r ? S_UNL2 : S_BR;
      S_UNL2: state_nxt = S_BR;
      S_BR: begin
        if (cmd_r == CMD_CANCEL) begin
          state_nxt = was_act_r ? S_CRD : S_FIN;
        end else if (delay_r[31] || delay_r == 32'd0) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_MUL1;
        end
      end
      S_CRD:  state_nxt = S_CF;
      S_CF:   state_nxt = (nrd == HEAD_IDX) ? S_FIN : S_CEXP;
      S_CEXP: state_nxt = S_FIN;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_WST;
      S_WST:  state_nxt = S_WALK;
      S_WALK: if (!walk_go) state_nxt = S_INS1;
      S_INS1: state_nxt = S_INS2;
      S_INS2: state_nxt = S_FIN;
      S_FIN:  if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= '0;
      tpu_r       <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        tpu_r <= cfg_data;
      end
      if (state_r == S_UNL2) begin
        act_r[slot_r] <= 1'b0;
      end
      if (state_r == S_INS2) begin
        act_r[slot_r] <= 1'b1;
      end
      if (state_r == S_FIN && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r        <= in_tuser;
      slot_r       <= in_tdata[3:0];
      delay_r      <= in_tdata[35:4];
      tol_u_r      <= in_tdata[66:36];
      now_r        <= in_tdata[130:67];
      last_r       <= in_tdata[194:131];
      was_act_r    <= act_r[in_tdata[3:0]];
      res_status_r <= ST_INACTIVE;
      res_upd_r    <= 1'b0;
      res_exp_r    <= 64'd0;
    end
    unique case (state_r)
      S_UNL1: begin
        nx_r <= nrd;
        ds_r <= drd_r;
      end
      S_BR: begin
        if (cmd_r == CMD_SET) begin
          if (delay_r[31]) begin
            res_status_r <= ST_INFINITE;
          end else if (delay_r == 32'd0) begin
            res_status_r <= ST_INSTANT;
          end
        end else if (was_act_r) begin
          res_status_r <= ST_CANCELLED;
        end
      end
      S_CEXP: begin
        res_upd_r <= 1'b1;
        res_exp_r <= last_r + drd_r;
      end
      S_MUL1: delayj_r <= mul_p;
      S_MUL2: begin
        tol_r <= mul_p;
        dj_r  <= (now_r - last_r) + delayj_r;
      end
      S_WST: begin
        first_r <= nrd;
        succ_r  <= nrd;
        guard_r <= '0;
      end
      S_WALK: begin
        if (walk_go) begin
          dj_r    <= dj_r - drd_r;
          succ_r  <= nrd;
          guard_r <= guard_r + LINK_W'(1);
        end else begin
          pv_r    <= prd;
          dsucc_r <= drd_r;
        end
      end
      S_INS2: begin
        res_status_r <= ST_QUEUED;
        if (succ_r == first_r) begin
          res_upd_r <= 1'b1;
          res_exp_r <= now_r + delayj_r;
        end
      end
      default: begin
      end
    endcase
    if (state_r == S_FIN && (!out_valid_r || out_tready)) begin
      out_status_r <= res_status_r;
      out_upd_r    <= res_upd_r;
      out_exp_r    <= res_exp_r;
      out_slot_r   <= slot_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_slot_r, out_exp_r};
  assign out_tuser  = {out_upd_r, out_status_r};

`ifndef SYNTHESIS
  a_guard_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> guard_r <= LINK_W'(TIMER_SLOTS))
    else $error("walk guard overran slot count");

  a_ins_active: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS2 |=> act_r[slot_r])
    else $error("inserted slot not marked active");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result word raised outside finish state");

  a_cancel_idle_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && cmd_r == CMD_CANCEL && !was_act_r) |-> res_status_r == ST_INACTIVE)
    else $error("cancel of idle slot gave wrong status");
`endif

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the delta-list timer queue. An in-bench model of
// the queue predicts each result word; a monitor compares every accepted
// result with the oldest prediction. Directed corner cases run first, then
// random request streams under several tick-rate settings. Both sides idle
// at random, and one phase stalls the receiver until the input backs up.
// ----------------------------------------------------------------------------
module testbench
  import dlq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]        status;
    logic              upd;
    logic [63:0]       exp_t;
    logic [SLOT_W-1:0] slot;
  } timer_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [199:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;
  logic [3:0]   out_tuser;

  // model state of the queue
  logic [63:0]       tick_rate;
  logic [63:0]       delta_q [TIMER_SLOTS];
  logic [LINK_W-1:0] next_q  [LINK_DEPTH];
  logic [LINK_W-1:0] prev_q  [LINK_DEPTH];
  logic              queued  [TIMER_SLOTS];

  timer_result_t pending_results [$];
  int  errors = 0;
  int  results_seen = 0;
  int  words_sent = 0;
  int  hold_len = 0;
  int  hold_cnt = 0;
  int  stall_cnt = 0;
  bit  idle_on = 1'b1;
  logic [63:0] clock_base;

  delta_list_timer_queue dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #2 clk = ~clk;

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // take a slot out of the queue, its delta goes to the successor
  function automatic void unlink_slot(input int s);
    logic [LINK_W-1:0] nx, pv;
    nx = next_q[s];
    pv = prev_q[s];
    next_q[pv] = nx;
    prev_q[nx] = pv;
    if (nx != HEAD_IDX) delta_q[nx] += delta_q[s];
    next_q[s] = HEAD_IDX;
    prev_q[s] = HEAD_IDX;
    queued[s] = 1'b0;
  endfunction

  function automatic void reset_queue();
    tick_rate = 64'd1;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      delta_q[i] = '0;
      queued[i] = 1'b0;
    end
    for (int i = 0; i < LINK_DEPTH; i++) begin
      next_q[i] = HEAD_IDX;
      prev_q[i] = HEAD_IDX;
    end
  endfunction

  function automatic timer_result_t predict_timer(input logic cmd, input logic [3:0] s,
      input logic [31:0] dly, input logic [30:0] tol_u, input logic [63:0] now,
      input logic [63:0] last);
    timer_result_t r;
    logic [63:0] delayj, tol, dj;
    logic [LINK_W-1:0] first, succ, pv;
    int guard;
    r = '0;
    r.status = ST_INACTIVE;
    r.slot = s;
    if (cmd == CMD_CANCEL) begin
      if (queued[s]) begin
        unlink_slot(s);
        first = next_q[HEAD_IDX];
        if (first != HEAD_IDX) begin
          r.upd = 1'b1;
          r.exp_t = last + delta_q[first];
        end
        r.status = ST_CANCELLED;
      end
    end else begin
      if (queued[s]) unlink_slot(s);
      if (dly[31]) r.status = ST_INFINITE;
      else if (dly == 0) r.status = ST_INSTANT;
      else begin
        delayj = {32'd0, dly} * tick_rate;
        tol = {33'd0, tol_u} * tick_rate;
        dj = (now - last) + delayj;
        first = next_q[HEAD_IDX];
        succ = first;
        guard = 0;
        while (succ != HEAD_IDX && guard < TIMER_SLOTS && delta_q[succ] < dj) begin
          dj -= delta_q[succ];
          succ = next_q[succ];
          guard++;
        end
        delta_q[s] = dj;
        pv = prev_q[succ];
        next_q[s] = succ;
        prev_q[s] = pv;
        next_q[pv] = LINK_W'(s);
        prev_q[succ] = LINK_W'(s);
        queued[s] = 1'b1;
        if (succ != HEAD_IDX) begin
          delta_q[succ] -= delta_q[s];
          // successor too close: fold it into this timer
          if (delta_q[succ] < tol) begin
            delta_q[s] += delta_q[succ];
            delta_q[succ] = '0;
          end
        end
        if (succ == first) begin
          r.upd = 1'b1;
          r.exp_t = now + delayj;
        end
        r.status = ST_QUEUED;
      end
    end
    return r;
  endfunction

  // receiver: random stalls per word, long hold-off on request; monitor
  always @(posedge clk) begin
    timer_result_t want;
    if (hold_len != 0) begin
      hold_cnt <= hold_len;
      hold_len = 0;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_tready <= 1'b0;
    end else if (rst_n) begin
      out_tready <= 1'b1;
      if (out_tvalid && out_tready && idle_on) stall_cnt <= $urandom_range(0, 12);
    end
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) report_mismatch("result word with none expected");
      else begin
        want = pending_results.pop_front();
        if (out_tuser[2:0] !== want.status)
          report_mismatch($sformatf("slot %0d status %0d want %0d", want.slot,
                          out_tuser[2:0], want.status));
        if (out_tuser[3] !== want.upd)
          report_mismatch($sformatf("slot %0d expiry_update %0b want %0b", want.slot,
                          out_tuser[3], want.upd));
        if (out_tdata[63:0] !== want.exp_t)
          report_mismatch($sformatf("slot %0d expiry_time %h want %h", want.slot,
                          out_tdata[63:0], want.exp_t));
        if (out_tdata[67:64] !== want.slot)
          report_mismatch($sformatf("slot_echo %0d want %0d", out_tdata[67:64], want.slot));
        if (out_tdata[71:68] !== 4'd0) report_mismatch("out_tdata pad not zero");
      end
    end
  end

  // send one request word and record its prediction on acceptance
  task automatic send_request(input logic cmd, input logic [3:0] s, input logic [31:0] dly,
      input logic [30:0] tol_u, input logic [63:0] now, input logic [63:0] last);
    int gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {5'd0, last, now, tol_u, dly, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_timer(cmd, s, dly, tol_u, now, last));
    words_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_tick_rate(input logic [31:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tick_rate = {32'd0, v};
  endtask

  // random request, mostly well-formed: small delays, recent time stamps
  task automatic send_random();
    logic cmd;
    logic [31:0] dly;
    logic [30:0] tol_u;
    logic [63:0] now, last;
    int pick;
    cmd = ($urandom_range(0, 3) == 0) ? CMD_CANCEL : CMD_SET;
    pick = $urandom_range(0, 99);
    if (pick < 60) dly = $urandom_range(1, 60);
    else if (pick < 70) dly = 32'd0;
    else if (pick < 80) dly = $urandom | 32'h8000_0000;
    else dly = $urandom;
    tol_u = ($urandom_range(0, 9) < 7) ? 31'($urandom_range(0, 6)) : 31'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      now = {$urandom, $urandom};
      last = {$urandom, $urandom};
    end else begin
      clock_base += $urandom_range(0, 8);
      last = clock_base;
      now = clock_base + $urandom_range(0, 10);
    end
    send_request(cmd, 4'($urandom), dly, tol_u, now, last);
  endtask

  task automatic test_directed();
    logic [63:0] t;
    t = 64'd1000;
    send_request(CMD_CANCEL, 4'd0, 32'd5, 31'd0, t, t);          // cancel, inactive
    send_request(CMD_SET, 4'd0, 32'd100, 31'd0, t, t);           // first timer at head
    send_request(CMD_SET, 4'd1, 32'd50, 31'd0, t + 3, t);        // new head
    send_request(CMD_SET, 4'd2, 32'd200, 31'd0, t, t);           // tail
    send_request(CMD_SET, 4'd3, 32'd102, 31'd10, t, t);          // between slots 0 and 2, no fold
    send_request(CMD_SET, 4'd0, 32'd10, 31'd0, t, t);            // set on queued slot
    send_request(CMD_SET, 4'd2, 32'd0, 31'd0, t, t);             // instant, unlinks
    send_request(CMD_SET, 4'd1, 32'h8000_0000, 31'd0, t, t);     // forever, unlinks
    send_request(CMD_SET, 4'd15, 32'h7FFF_FFFF, 31'h7FFF_FFFF, t, t);
    send_request(CMD_CANCEL, 4'd0, 32'hFFFF_FFFF, 31'd0, t, t);  // cancel head
    send_request(CMD_CANCEL, 4'd3, 32'd0, 31'd0, t, t);
    send_request(CMD_CANCEL, 4'd15, 32'd0, 31'd0, t, t);         // queue left empty
    send_request(CMD_SET, 4'd4, 32'hFFFF_FFFF, 31'd0, t, t);     // all-ones delay
    send_request(CMD_SET, 4'd5, 32'd7, 31'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    send_request(CMD_SET, 4'd6, 32'd9, 31'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    write_tick_rate(32'hFFFF_FFFF);
    send_request(CMD_SET, 4'd7, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0, t);
    send_request(CMD_SET, 4'd8, 32'd1, 31'd1, t, t);
    write_tick_rate(32'd0);
    send_request(CMD_SET, 4'd9, 32'd40, 31'd3, t + 5, t);        // zero rate still queues
    send_request(CMD_SET, 4'd10, 32'd1, 31'd0, t, t);
    for (int i = 0; i < TIMER_SLOTS; i++)
      send_request(CMD_CANCEL, 4'(i), 32'd0, 31'd0, t, t);
    write_tick_rate(32'd1);
  endtask

  task automatic test_random(input int count, input logic [31:0] rate);
    write_tick_rate(rate);
    for (int i = 0; i < count; i++) begin
      // some stretches with no idling on either side
      if (i % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_random();
    end
    idle_on = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    wait_drained();
    hold_len = 400;
    idle_on = 1'b0;
    for (int i = 0; i < 40; i++) send_random();
    idle_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    reset_queue();
    clock_base = 64'd5000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300, 32'd1);
    test_random(200, 32'd3);
    test_backpressure();
    test_random(200, 32'hFFFF_FFFF);
    test_random(150, 32'd0);
    test_random(250, $urandom);
    wait_drained();
    $display("Run covered %0d request words and %0d result words over tick rates", words_sent,
             results_seen);
    $display("1, 3, max, 0 and random, with idling, stalls and one long output hold-off.");
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
